### src/crsfr_pkg.sv
`default_nettype none
package crsfr_pkg;

   localparam int unsigned MaxFrame = 64;
   localparam int unsigned PtrW     = $clog2(MaxFrame);
   localparam int unsigned CntW     = PtrW + 1;
   localparam logic [7:0]  CrcPoly  = 8'hD5;
   localparam logic [7:0]  CrcTop   = 8'h80;

   localparam logic [2:0] KindHeader   = 3'd0;
   localparam logic [2:0] KindPayload  = 3'd1;
   localparam logic [2:0] KindFrameErr = 3'd2;
   localparam logic [2:0] KindCrcErr   = 3'd3;
   localparam logic [2:0] KindEcho     = 3'd4;

   typedef enum logic [2:0] {
      OFF_HOLD  = 3'd0,
      OFF_ZERO  = 3'd1,
      OFF_ONE   = 3'd2,
      OFF_TWO   = 3'd3,
      OFF_THREE = 3'd4,
      OFF_INC   = 3'd5
   } off_op_type;

   typedef struct packed {
      logic       rx_load;
      logic       echo_load;
      off_op_type off_op;
      logic       crc_clr;
      logic       crc_adv;
      logic       body_ld;
      logic       addr_ld;
      logic       type_ld;
      logic       push;
      logic [2:0] push_kind;
      logic       drop_one;
      logic       drop_frame;
      logic       flush;
   } cmd_type;

   typedef struct packed {
      logic cnt_lt2;
      logic body_bad;
      logic too_short;
      logic crc_end;
      logic crc_ok;
      logic echo_cand;
      logic cmp_ne;
      logic pay_end;
      logic plen_zero;
      logic can_emit;
      logic pend_valid;
      logic out_free;
   } status_type;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((c & CrcTop) != 8'd0) begin
            c = (c << 1) ^ CrcPoly;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### src/crsfr_ram.sv
`default_nettype none
module crsfr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### src/crsfr_ctrl.sv
`default_nettype none
module crsfr_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_tvalid,
   output      logic                 req_tready,
   input  wire logic                 req_action,
   input  wire crsfr_pkg::status_type sts,
   output      crsfr_pkg::cmd_type   cmd
);
   import crsfr_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SCAN   = 9'b000000010,
      ST_BODY   = 9'b000000100,
      ST_CRC    = 9'b000001000,
      ST_CMP    = 9'b000010000,
      ST_HDR_A  = 9'b000100000,
      ST_HDR_T  = 9'b001000000,
      ST_PAY    = 9'b010000000,
      ST_FINISH = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      cmd.off_op = OFF_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_action) begin
                  cmd.echo_load = 1'b1;
               end else begin
                  cmd.rx_load = 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (sts.cnt_lt2) begin
               state_in = ST_FINISH;
            end else begin
               cmd.off_op = OFF_ONE;
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            priority if (sts.body_bad) begin
               if (sts.can_emit) begin
                  cmd.push = 1'b1;
                  cmd.push_kind = KindFrameErr;
                  cmd.drop_one = 1'b1;
                  state_in = ST_SCAN;
               end
            end else if (sts.too_short) begin
               state_in = ST_FINISH;
            end else begin
               cmd.body_ld = 1'b1;
               cmd.crc_clr = 1'b1;
               cmd.off_op = OFF_TWO;
               state_in = ST_CRC;
            end
         end
         ST_CRC: begin
            priority if (!sts.crc_end) begin
               cmd.crc_adv = 1'b1;
               cmd.off_op = OFF_INC;
            end else if (!sts.crc_ok) begin
               if (sts.can_emit) begin
                  cmd.push = 1'b1;
                  cmd.push_kind = KindCrcErr;
                  cmd.drop_one = 1'b1;
                  state_in = ST_SCAN;
               end
            end else begin
               cmd.off_op = OFF_ZERO;
               state_in = sts.echo_cand ? ST_CMP : ST_HDR_A;
            end
         end
         ST_CMP: begin
            priority if (sts.cmp_ne) begin
               cmd.off_op = OFF_ZERO;
               state_in = ST_HDR_A;
            end else if (sts.crc_end) begin
               if (sts.can_emit) begin
                  cmd.push = 1'b1;
                  cmd.push_kind = KindEcho;
                  cmd.drop_frame = 1'b1;
                  state_in = ST_SCAN;
               end
            end else begin
               cmd.off_op = OFF_INC;
            end
         end
         ST_HDR_A: begin
            cmd.addr_ld = 1'b1;
            cmd.off_op = OFF_TWO;
            state_in = ST_HDR_T;
         end
         ST_HDR_T: begin
            cmd.type_ld = 1'b1;
            if (sts.can_emit) begin
               cmd.push = 1'b1;
               cmd.push_kind = KindHeader;
               if (sts.plen_zero) begin
                  cmd.drop_frame = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  cmd.off_op = OFF_THREE;
                  state_in = ST_PAY;
               end
            end
         end
         ST_PAY: begin
            if (sts.can_emit) begin
               cmd.push = 1'b1;
               cmd.push_kind = KindPayload;
               if (sts.pay_end) begin
                  cmd.drop_frame = 1'b1;
                  state_in = ST_SCAN;
               end else begin
                  cmd.off_op = OFF_INC;
               end
            end
         end
         ST_FINISH: begin
            if (!sts.pend_valid) begin
               state_in = ST_IDLE;
            end else if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule
`default_nettype wire

### src/crsfr_dpath.sv
`default_nettype none
module crsfr_dpath (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [7:0]            req_data,
   input  wire logic                  req_last,
   input  wire crsfr_pkg::cmd_type    cmd,
   output      crsfr_pkg::status_type sts,
   output      logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   output      logic [2:0]            rsp_kind,
   output      logic [7:0]            rsp_address,
   output      logic [7:0]            rsp_frame_type,
   output      logic [5:0]            rsp_payload_length,
   output      logic [7:0]            rsp_data_byte,
   output      logic                  rsp_run_last
);
   import crsfr_pkg::*;

   logic [PtrW-1:0] head_ff, head_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [PtrW-1:0] off_ff, off_in;
   logic [PtrW-1:0] body_ff;
   logic [7:0]      crc_ff, addr_ff, type_ff;
   logic [CntW-1:0] echo_len_ff, echo_idx_ff, echo_idx_in;
   logic            echo_valid_ff;
   logic [7:0]      rx_rd, echo_rd;
   logic [CntW-1:0] size, rd_size;
   logic            rx_we;

   logic            pend_valid_ff;
   logic [2:0]      pend_kind_ff;
   logic [7:0]      pend_addr_ff, pend_type_ff, pend_byte_ff;
   logic [5:0]      pend_plen_ff;
   logic            out_valid_ff, out_free, can_emit;

   assign size    = CntW'(body_ff) + CntW'(2);
   assign rd_size = CntW'(rx_rd[PtrW-1:0]) + CntW'(2);
   assign rx_we   = cmd.rx_load && (count_ff < CntW'(MaxFrame));

   always_comb begin
      unique case (cmd.off_op)
         OFF_HOLD:  off_in = off_ff;
         OFF_ZERO:  off_in = '0;
         OFF_ONE:   off_in = PtrW'(1);
         OFF_TWO:   off_in = PtrW'(2);
         OFF_THREE: off_in = PtrW'(3);
         OFF_INC:   off_in = off_ff + PtrW'(1);
         default:   off_in = off_ff;
      endcase
   end

   crsfr_ram #(.WIDTH(8), .DEPTH(MaxFrame)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (head_ff + count_ff[PtrW-1:0]),
      .wr_data (req_data),
      .rd_addr (head_ff + off_in),
      .rd_data (rx_rd)
   );

   crsfr_ram #(.WIDTH(8), .DEPTH(MaxFrame)) u_echo_ram (
      .clock   (clock),
      .wr_en   (cmd.echo_load && (echo_idx_ff < CntW'(MaxFrame))),
      .wr_addr (echo_idx_ff[PtrW-1:0]),
      .wr_data (req_data),
      .rd_addr (off_in),
      .rd_data (echo_rd)
   );

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      priority if (rx_we) begin
         count_in = count_ff + CntW'(1);
      end else if (cmd.drop_one) begin
         head_in  = head_ff + PtrW'(1);
         count_in = count_ff - CntW'(1);
      end else if (cmd.drop_frame) begin
         head_in  = head_ff + size[PtrW-1:0];
         count_in = count_ff - size;
      end
   end

   assign echo_idx_in = (echo_idx_ff < CntW'(MaxFrame)) ? echo_idx_ff + CntW'(1)
                                                       : echo_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         echo_len_ff   <= '0;
         echo_idx_ff   <= '0;
         echo_valid_ff <= 1'b0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
         if (cmd.echo_load) begin
            if (req_last) begin
               echo_len_ff   <= echo_idx_in;
               echo_valid_ff <= 1'b1;
               echo_idx_ff   <= '0;
            end else begin
               echo_idx_ff <= echo_idx_in;
               if (echo_idx_ff == '0) begin
                  echo_valid_ff <= 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      off_ff <= off_in;
      if (cmd.body_ld) begin
         body_ff <= rx_rd[PtrW-1:0];
      end
      if (cmd.crc_clr) begin
         crc_ff <= '0;
      end else if (cmd.crc_adv) begin
         crc_ff <= crc_step(crc_ff, rx_rd);
      end
      if (cmd.addr_ld) begin
         addr_ff <= rx_rd;
      end
      if (cmd.type_ld) begin
         type_ff <= rx_rd;
      end
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign can_emit = !pend_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (cmd.push) begin
            pend_valid_ff <= 1'b1;
            if (pend_valid_ff) begin
               out_valid_ff <= 1'b1;
            end
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
            out_valid_ff  <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if ((cmd.push && pend_valid_ff) || cmd.flush) begin
         rsp_kind           <= pend_kind_ff;
         rsp_address        <= pend_addr_ff;
         rsp_frame_type     <= pend_type_ff;
         rsp_payload_length <= pend_plen_ff;
         rsp_data_byte      <= pend_byte_ff;
         rsp_run_last       <= cmd.flush;
      end
      if (cmd.push) begin
         pend_kind_ff <= cmd.push_kind;
         if (cmd.push_kind == KindHeader || cmd.push_kind == KindPayload) begin
            pend_addr_ff <= addr_ff;
            pend_type_ff <= (cmd.push_kind == KindHeader) ? rx_rd : type_ff;
            pend_plen_ff <= 6'(body_ff - PtrW'(2));
            pend_byte_ff <= (cmd.push_kind == KindPayload) ? rx_rd : 8'd0;
         end else begin
            pend_addr_ff <= '0;
            pend_type_ff <= '0;
            pend_plen_ff <= '0;
            pend_byte_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;

   always_comb begin
      sts.cnt_lt2    = count_ff < CntW'(2);
      sts.body_bad   = (rx_rd < 8'd2) || (rx_rd > 8'(MaxFrame - 2));
      sts.too_short  = count_ff < rd_size;
      sts.crc_end    = off_ff == body_ff + PtrW'(1);
      sts.crc_ok     = crc_ff == rx_rd;
      sts.echo_cand  = echo_valid_ff && (size == echo_len_ff);
      sts.cmp_ne     = rx_rd != echo_rd;
      sts.pay_end    = off_ff == body_ff;
      sts.plen_zero  = body_ff == PtrW'(2);
      sts.can_emit   = can_emit;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = out_free;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(MaxFrame))
      else $error("receive count exceeds buffer");
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.push || cmd.flush) |-> (cmd.flush ? out_free : can_emit))
      else $error("result pushed without room");
   a_drop_frame: assert property (@(posedge clock) disable iff (reset)
      cmd.drop_frame |-> (count_ff >= size))
      else $error("frame drop beyond buffered bytes");
   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> (rsp_tvalid && rsp_run_last && !pend_valid_ff))
      else $error("flush did not present last result");
endmodule
`default_nettype wire

### src/crsf_frame_receiver_core.sv
`default_nettype none
// CRSF deframer: received bytes (req_tuser=0) enter a 64-byte ring buffer and the
// buffer is rescanned; reference bytes (req_tuser=1, req_tlast on the final one)
// load the echo reference and give no result. Each received byte rescans the
// buffer by reading buffered bytes one at a time (CRC walk over the frame, echo
// compare over the frame, then the header and one payload result per payload
// byte), all through the single read port of the receive buffer RAM.
// A framing or CRC error drops one byte and rescans, so one byte can take several
// such walks, and it stalls while the result output is held. Input is taken only
// between items. rsp_tlast marks the last result of an input byte.
module crsf_frame_receiver_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data
   input  wire logic        req_tuser,   // [0] action
   input  wire logic        req_tlast,   // ref_last
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [31:0] rsp_tdata,   // [7:0] address, [15:8] frame_type,
                                         // [21:16] payload_length, [29:22] data_byte
   output      logic [2:0]  rsp_tuser,   // [2:0] kind
   output      logic        rsp_tlast    // run_last
);
   import crsfr_pkg::*;

   cmd_type    cmd;
   status_type sts;
   logic [7:0] address, frame_type, data_byte;
   logic [5:0] payload_length;

   crsfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .sts        (sts),
      .cmd        (cmd)
   );

   crsfr_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .req_data           (req_tdata),
      .req_last           (req_tlast),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_kind           (rsp_tuser),
      .rsp_address        (address),
      .rsp_frame_type     (frame_type),
      .rsp_payload_length (payload_length),
      .rsp_data_byte      (data_byte),
      .rsp_run_last       (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, data_byte, payload_length, frame_type, address};
endmodule
`default_nettype wire

### test/crsf_frame_receiver_core_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module crsf_frame_receiver_core_tb;
   import crsfr_pkg::*;

   localparam int unsigned StallLimit = 20000;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] address;
      logic [7:0] frame_type;
      logic [5:0] payload_length;
      logic [7:0] data_byte;
      logic       run_last;
   } frame_event_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   crsf_frame_receiver_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   logic [7:0]      rx_buf [MaxFrame];
   int unsigned     rx_fill;
   logic [7:0]      echo_buf [MaxFrame];
   int unsigned     echo_len;
   bit              echo_ok;
   int unsigned     echo_pos;
   frame_event_type expected_events [$];

   int unsigned  error_count;
   int unsigned  idle_cycles;
   int unsigned  send_idle_pct;
   int unsigned  recv_idle_pct;
   int unsigned  hold_cycles;
   logic [7:0]   echo_frame [$];

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic logic [7:0] crc_dvb_s2(logic [7:0] crc, logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ((c << 1) ^ 8'hD5) : (c << 1);
      end
      return c;
   endfunction

   function automatic void shift_out(int unsigned k);
      if (k >= rx_fill) begin
         rx_fill = 0;
      end else begin
         for (int unsigned i = 0; i < rx_fill - k; i++) rx_buf[i] = rx_buf[i + k];
         rx_fill -= k;
      end
   endfunction

   function automatic void push_event(logic [2:0] kind, logic [7:0] a, logic [7:0] t,
                                      logic [5:0] pl, logic [7:0] d);
      frame_event_type ev;
      ev = '{kind, a, t, pl, d, 1'b0};
      expected_events.insert(expected_events.size(), ev);
   endfunction

   function automatic void predict_frames(logic action, logic [7:0] data, logic last);
      int unsigned body;
      int unsigned size;
      int unsigned n_before;
      logic [7:0]  crc;
      bit          same;
      frame_event_type ev;
      n_before = expected_events.size();
      if (action) begin
         if (echo_pos == 0) echo_ok = 0;
         if (echo_pos < MaxFrame) begin
            echo_buf[echo_pos] = data;
            echo_pos++;
         end
         if (last) begin
            echo_len = echo_pos;
            echo_ok  = 1;
            echo_pos = 0;
         end
         return;
      end
      if (rx_fill < MaxFrame) begin
         rx_buf[rx_fill] = data;
         rx_fill++;
      end
      while (rx_fill >= 2) begin
         body = rx_buf[1];
         if (body < 2 || body > MaxFrame - 2) begin
            shift_out(1);
            push_event(KindFrameErr, 8'd0, 8'd0, 6'd0, 8'd0);
            continue;
         end
         size = body + 2;
         if (rx_fill < size) break;
         crc = 8'h00;
         for (int unsigned i = 2; i + 1 < size; i++) crc = crc_dvb_s2(crc, rx_buf[i]);
         if (crc != rx_buf[size - 1]) begin
            shift_out(1);
            push_event(KindCrcErr, 8'd0, 8'd0, 6'd0, 8'd0);
            continue;
         end
         same = echo_ok && size == echo_len;
         for (int unsigned i = 0; same && i < size; i++)
            if (rx_buf[i] != echo_buf[i]) same = 0;
         if (same) begin
            push_event(KindEcho, 8'd0, 8'd0, 6'd0, 8'd0);
         end else begin
            push_event(KindHeader, rx_buf[0], rx_buf[2], 6'(body - 2), 8'd0);
            for (int unsigned i = 0; i < body - 2; i++)
               push_event(KindPayload, rx_buf[0], rx_buf[2], 6'(body - 2), rx_buf[3 + i]);
         end
         shift_out(size);
      end
      if (expected_events.size() > n_before) begin
         ev = expected_events.pop_back();
         ev.run_last = 1'b1;
         expected_events.insert(expected_events.size(), ev);
      end
   endfunction

   task automatic report_mismatch(string what, int unsigned got, int unsigned want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   always @(posedge clock) begin
      frame_event_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_events.size() == 0) begin
            report_mismatch("unexpected transaction kind", rsp_tuser, 0);
         end else begin
            want = expected_events.pop_front();
            if (rsp_tuser != want.kind) report_mismatch("kind", rsp_tuser, want.kind);
            if (rsp_tdata[7:0] != want.address)
               report_mismatch("address", rsp_tdata[7:0], want.address);
            if (rsp_tdata[15:8] != want.frame_type)
               report_mismatch("frame_type", rsp_tdata[15:8], want.frame_type);
            if (rsp_tdata[21:16] != want.payload_length)
               report_mismatch("payload_length", rsp_tdata[21:16], want.payload_length);
            if (rsp_tdata[29:22] != want.data_byte)
               report_mismatch("data_byte", rsp_tdata[29:22], want.data_byte);
            if (rsp_tdata[31:30] != 2'b00) report_mismatch("pad", rsp_tdata[31:30], 0);
            if (rsp_tlast != want.run_last) report_mismatch("run_last", rsp_tlast, want.run_last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= StallLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // hold off the receiver while hold_cycles runs down
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic send_byte(logic action, logic [7:0] data, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= action;
      req_tdata  <= data;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_frames(action, data, last);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_events.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic make_frame(logic [7:0] addr, int unsigned plen, bit bad_crc);
      logic [7:0] crc;
      logic [7:0] b;
      echo_frame.delete();
      echo_frame.insert(echo_frame.size(), addr);
      echo_frame.insert(echo_frame.size(), 8'(plen + 2));
      b = 8'($urandom_range(255));
      echo_frame.insert(echo_frame.size(), b);
      crc = crc_dvb_s2(8'h00, b);
      for (int unsigned i = 0; i < plen; i++) begin
         b = 8'($urandom_range(255));
         echo_frame.insert(echo_frame.size(), b);
         crc = crc_dvb_s2(crc, b);
      end
      echo_frame.insert(echo_frame.size(), bad_crc ? ~crc : crc);
   endtask

   task automatic send_frame();
      foreach (echo_frame[i]) send_byte(1'b0, echo_frame[i], 1'b0);
   endtask

   task automatic load_reference();
      foreach (echo_frame[i]) send_byte(1'b1, echo_frame[i], i == echo_frame.size() - 1);
   endtask

   task automatic test_directed();
      make_frame(8'hC8, 0, 0);
      send_frame();
      make_frame(8'hFF, 3, 0);
      send_frame();
      send_byte(1'b0, 8'h00, 1'b0);
      send_byte(1'b0, 8'h01, 1'b0);
      send_byte(1'b0, 8'hEE, 1'b0);
      send_byte(1'b0, 8'h3F, 1'b0);
      make_frame(8'h00, 2, 1);
      send_frame();
      make_frame(8'hEA, 58, 0);
      load_reference();
      send_frame();
      drain_results();
   endtask

   task automatic test_random_traffic(int unsigned count);
      int unsigned sel;
      for (int unsigned k = 0; k < count;) begin
         sel = $urandom_range(99);
         if (sel < 55) begin
            make_frame(8'($urandom_range(255)),
                       ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(6),
                       $urandom_range(5) == 0);
            send_frame();
            k += echo_frame.size();
         end else if (sel < 70) begin
            make_frame(8'($urandom_range(255)), $urandom_range(5), 0);
            load_reference();
            k += echo_frame.size();
            if ($urandom_range(1)) begin
               send_frame();
               k += echo_frame.size();
            end
         end else if (sel < 93) begin
            send_byte(1'b0, 8'($urandom_range(255)), 1'($urandom_range(1)));
            k++;
         end else begin
            send_byte(1'b1, 8'($urandom_range(255)), 1'($urandom_range(1)));
            k++;
         end
      end
   endtask

   task automatic test_long_reference();
      for (int unsigned i = 0; i < 70; i++) send_byte(1'b1, 8'(i), i == 69);
      drain_results();
   endtask

   task automatic test_backpressure();
      hold_cycles = 3000;
      make_frame(8'h11, 20, 0);
      send_frame();
      send_frame();
      drain_results();
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'h00;
      req_tuser     = 1'b0;
      req_tlast     = 1'b0;
      error_count   = 0;
      hold_cycles   = 0;
      rx_fill       = 0;
      echo_len      = 0;
      echo_ok       = 0;
      echo_pos      = 0;
      send_idle_pct = 18;
      recv_idle_pct = 68;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_long_reference();
      test_random_traffic(60);
      drain_results();
      send_idle_pct = 68;
      recv_idle_pct = 18;
      test_random_traffic(60);
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_backpressure();
      test_random_traffic(60);
      drain_results();

      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire
